### hw/rtl/script_word_tokenizer_macros.svh
// Assertion macros shared by the tokenizer checks.
`ifndef SCRIPT_WORD_TOKENIZER_MACROS_SVH
`define SCRIPT_WORD_TOKENIZER_MACROS_SVH

// Checked at every clock edge outside of reset.
`define SWT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SWT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/swt_pkg.sv
package swt_pkg;

  localparam int unsigned WordLimit  = 36;
  localparam int unsigned LenW       = 6;
  localparam int unsigned CntW       = 9;
  localparam int unsigned SkipW      = 9;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [CntW-1:0] CountSat = CntW'(256);
  localparam logic [CntW-1:0] LenMax   = CntW'(255);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LOW_S  = 8'h73;
  localparam logic [7:0] CH_UP_S   = 8'h53;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_UP_B   = 8'h42;
  localparam logic [7:0] CH_LOW_X  = 8'h78;

  typedef enum logic [2:0] {
    CLS_SEP   = 3'd0,
    CLS_CHAR  = 3'd1,
    CLS_WEND  = 3'd2,
    CLS_BODY  = 3'd3,
    CLS_CLOSE = 3'd4,
    CLS_CMT   = 3'd5,
    CLS_LEN   = 3'd6
  } class_e;

  typedef enum logic [2:0] {
    KIND_ORD   = 3'd0,
    KIND_DOTQ  = 3'd1,
    KIND_SQ    = 3'd2,
    KIND_BQ    = 3'd3,
    KIND_LCMT  = 3'd4
  } kind_e;

  // Decoded byte handed from the front to the back through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_sep;
    logic       is_nl;
    logic       is_nul;
    logic       is_quote;
    logic       is_x;
    logic       is_bslash;
  } byte_info_t;

endpackage

### hw/rtl/swt_front.sv
module swt_front (
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            script_byte_i,
  input  logic                  buffer_end_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output swt_pkg::byte_info_t   push_info_o
);

  logic [7:0] c;

  assign c = script_byte_i;

  always_comb begin
    push_info_o.data      = c;
    push_info_o.last      = buffer_end_i;
    push_info_o.is_nul    = (c == swt_pkg::CH_NUL);
    push_info_o.is_nl     = (c == swt_pkg::CH_LF);
    push_info_o.is_sep    = (c == swt_pkg::CH_SPACE) || (c == swt_pkg::CH_TAB) ||
                            (c == swt_pkg::CH_LF) || (c == swt_pkg::CH_CR) ||
                            (c == swt_pkg::CH_NUL);
    push_info_o.is_quote  = (c == swt_pkg::CH_QUOTE);
    push_info_o.is_x      = (c == swt_pkg::CH_LOW_X);
    push_info_o.is_bslash = (c == swt_pkg::CH_BSLASH);
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

### hw/rtl/swt_fifo.sv
module swt_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  swt_pkg::byte_info_t push_info_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output swt_pkg::byte_info_t pop_info_o
);

  swt_pkg::byte_info_t              slots_q [swt_pkg::QueueDepth];
  logic [swt_pkg::QPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [swt_pkg::QPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [swt_pkg::QCntW-1:0]        count_q, count_d;
  logic                             push, pop;

  assign push_ready_o = (count_q != swt_pkg::QCntW'(swt_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_info_o   = slots_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == swt_pkg::QPtrW'(swt_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == swt_pkg::QPtrW'(swt_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_info_i;
    end
  end

endmodule

### hw/rtl/swt_back.sv
module swt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  swt_pkg::byte_info_t pop_info_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          byte_class_o,
  output logic [7:0]          word_char_o,
  output logic                word_done_o,
  output logic [2:0]          word_kind_o,
  output logic                length_valid_o,
  output logic [7:0]          length_value_o,
  output logic                eof_error_o
);

  typedef enum logic [6:0] {
    MODE_IDLE    = 7'b0000001,
    MODE_WORD    = 7'b0000010,
    MODE_STR     = 7'b0000100,
    MODE_BLEN    = 7'b0001000,
    MODE_SKIP    = 7'b0010000,
    MODE_BX      = 7'b0100000,
    MODE_COMMENT = 7'b1000000
  } mode_e;

  mode_e                       mode_q, mode_d;
  logic [swt_pkg::LenW-1:0]    len_q, len_d, base_len;
  logic [15:0]                 head_q, head_d, base_head;
  logic [swt_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [swt_pkg::SkipW-1:0]   skip_q, skip_d;
  logic                        bsl_q, bsl_d;
  logic                        do_char;

  swt_pkg::class_e             cls;
  swt_pkg::kind_e              kind;
  logic [7:0]                  wc, lval;
  logic                        done, lv, eof;

  logic                        out_valid_q;
  logic [2:0]                  class_q, kind_q;
  logic [7:0]                  wc_q, lval_q;
  logic                        done_q, lv_q, eof_q;
  logic                        step;

  swt_pkg::byte_info_t         b;

  assign b = pop_info_i;

  function automatic swt_pkg::kind_e kind_of(input logic [swt_pkg::LenW-1:0] len,
                                             input logic [15:0] head);
    logic [7:0] c0, c1;
    c0 = head[7:0];
    c1 = head[15:8];
    kind_of = swt_pkg::KIND_ORD;
    if (len == swt_pkg::LenW'(1) && c0 == swt_pkg::CH_BSLASH) begin
      kind_of = swt_pkg::KIND_LCMT;
    end else if (len == swt_pkg::LenW'(2)) begin
      if (c1 == swt_pkg::CH_QUOTE) begin
        if (c0 == swt_pkg::CH_DOT) begin
          kind_of = swt_pkg::KIND_DOTQ;
        end else if (c0 == swt_pkg::CH_LOW_S || c0 == swt_pkg::CH_UP_S) begin
          kind_of = swt_pkg::KIND_SQ;
        end else if (c0 == swt_pkg::CH_LOW_B || c0 == swt_pkg::CH_UP_B) begin
          kind_of = swt_pkg::KIND_BQ;
        end
      end else if (c0 == swt_pkg::CH_SLASH && c1 == swt_pkg::CH_SLASH) begin
        kind_of = swt_pkg::KIND_LCMT;
      end
    end
  endfunction

  function automatic mode_e enter_scan(input swt_pkg::kind_e k, input logic nul,
                                       input logic nl);
    enter_scan = MODE_IDLE;
    unique case (k)
      swt_pkg::KIND_DOTQ, swt_pkg::KIND_SQ: enter_scan = nul ? MODE_IDLE : MODE_STR;
      swt_pkg::KIND_BQ:                     enter_scan = MODE_BLEN;
      swt_pkg::KIND_LCMT:                   enter_scan = nl ? MODE_IDLE : MODE_COMMENT;
      default:                              enter_scan = MODE_IDLE;
    endcase
  endfunction

  always_comb begin
    mode_d    = mode_q;
    len_d     = len_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    skip_d    = skip_q;
    bsl_d     = bsl_q;
    base_len  = len_q;
    base_head = head_q;
    do_char   = 1'b0;
    cls       = swt_pkg::CLS_SEP;
    kind      = swt_pkg::KIND_ORD;
    wc        = '0;
    done      = 1'b0;
    lv        = 1'b0;
    lval      = '0;
    eof       = 1'b0;

    unique case (mode_q)
      MODE_STR: begin
        if (b.is_nul || b.is_quote) begin
          cls    = swt_pkg::CLS_CLOSE;
          mode_d = MODE_IDLE;
        end else begin
          cls = swt_pkg::CLS_BODY;
        end
      end
      MODE_BLEN: begin
        cls = swt_pkg::CLS_LEN;
        if (b.is_x) begin
          cnt_d  = '0;
          bsl_d  = 1'b0;
          mode_d = MODE_BX;
        end else begin
          skip_d = swt_pkg::SkipW'(b.data) + swt_pkg::SkipW'(1);
          mode_d = MODE_SKIP;
        end
      end
      MODE_SKIP: begin
        if (skip_q <= swt_pkg::SkipW'(1)) begin
          cls    = swt_pkg::CLS_CLOSE;
          skip_d = '0;
          mode_d = MODE_IDLE;
        end else begin
          cls    = swt_pkg::CLS_BODY;
          skip_d = skip_q - 1'b1;
        end
      end
      MODE_BX: begin
        if (b.is_quote && !bsl_q) begin
          cls    = swt_pkg::CLS_CLOSE;
          lv     = 1'b1;
          lval   = (cnt_q > swt_pkg::LenMax) ? 8'd0 : cnt_q[7:0];
          mode_d = MODE_IDLE;
        end else begin
          cls = swt_pkg::CLS_BODY;
          if (cnt_q != swt_pkg::CountSat) begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        bsl_d = b.is_bslash;
      end
      MODE_COMMENT: begin
        if (b.is_nl) begin
          cls    = swt_pkg::CLS_SEP;
          mode_d = MODE_IDLE;
        end else begin
          cls = swt_pkg::CLS_CMT;
        end
      end
      MODE_WORD: begin
        if (b.is_sep) begin
          cls    = swt_pkg::CLS_WEND;
          done   = 1'b1;
          kind   = kind_of(len_q, head_q);
          mode_d = enter_scan(kind, b.is_nul, b.is_nl);
        end else begin
          do_char = 1'b1;
        end
      end
      default: begin
        // between words; unused codes behave the same
        if (b.is_sep) begin
          mode_d = MODE_IDLE;
        end else begin
          do_char   = 1'b1;
          base_len  = '0;
          base_head = '0;
        end
      end
    endcase

    if (do_char) begin
      head_d = base_head;
      if (base_len == swt_pkg::LenW'(0)) begin
        head_d[7:0] = b.data;
      end else if (base_len == swt_pkg::LenW'(1)) begin
        head_d[15:8] = b.data;
      end
      len_d  = (base_len == '1) ? base_len : base_len + 1'b1;
      cls    = swt_pkg::CLS_CHAR;
      wc     = b.data;
      mode_d = MODE_WORD;
      // cut the word at the limit or at the buffer end
      if (len_d >= swt_pkg::LenW'(swt_pkg::WordLimit) || b.last) begin
        done   = 1'b1;
        kind   = kind_of(len_d, head_d);
        eof    = b.last && (kind != swt_pkg::KIND_ORD);
        mode_d = MODE_IDLE;
      end
    end

    if (b.last) begin
      if (mode_d != MODE_IDLE && mode_d != MODE_WORD) begin
        eof = 1'b1;
      end
      mode_d = MODE_IDLE;
    end
  end

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign step        = pop_valid_i && pop_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      len_q       <= '0;
      head_q      <= '0;
      cnt_q       <= '0;
      skip_q      <= '0;
      bsl_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        mode_q <= mode_d;
        len_q  <= len_d;
        head_q <= head_d;
        cnt_q  <= cnt_d;
        skip_q <= skip_d;
        bsl_q  <= bsl_d;
      end
      if (pop_ready_o) begin
        out_valid_q <= pop_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      class_q <= cls;
      wc_q    <= wc;
      done_q  <= done;
      kind_q  <= kind;
      lv_q    <= lv;
      lval_q  <= lval;
      eof_q   <= eof;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_class_o   = class_q;
  assign word_char_o    = wc_q;
  assign word_done_o    = done_q;
  assign word_kind_o    = kind_q;
  assign length_valid_o = lv_q;
  assign length_value_o = lval_q;
  assign eof_error_o    = eof_q;

endmodule

### hw/rtl/script_word_tokenizer.sv
// Script word tokenizer: one classification result for every script byte.
// Input channel: script_byte_i with buffer_end_i marking the last byte of a
// buffer, transferred on in_valid_i and in_ready_o. Output channel: the
// result fields, transferred on out_valid_o and out_ready_i, in input order.
// Each transferred byte is written into the queue, and the back end then
// registers its result in the output register. Throughput: one byte per
// cycle while results are taken; the byte state machine settles each byte.
// The front end decodes each byte and writes it into a two-entry queue; the
// back end pops the queue into an output register. When the receiver stalls,
// the output register holds its result, the queue fills, and in_ready_o drops
// after two more bytes; it rises again once a result is taken and the queue pops.
// Reset empties the queue, drops out_valid_o and puts the scanner between
// words. After any byte with buffer_end_i the scanner is between words again.
module script_word_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] script_byte_i,
  input  logic       buffer_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] byte_class_o,
  output logic [7:0] word_char_o,
  output logic       word_done_o,
  output logic [2:0] word_kind_o,
  output logic       length_valid_o,
  output logic [7:0] length_value_o,
  output logic       eof_error_o
);

  logic                push_valid, push_ready;
  logic                pop_valid, pop_ready;
  swt_pkg::byte_info_t push_info, pop_info;

  swt_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .script_byte_i (script_byte_i),
    .buffer_end_i  (buffer_end_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_info_o   (push_info)
  );

  swt_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_info_i  (push_info),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_info_o   (pop_info)
  );

  swt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_info_i     (pop_info),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .byte_class_o   (byte_class_o),
    .word_char_o    (word_char_o),
    .word_done_o    (word_done_o),
    .word_kind_o    (word_kind_o),
    .length_valid_o (length_valid_o),
    .length_value_o (length_value_o),
    .eof_error_o    (eof_error_o)
  );

endmodule

### hw/rtl/swt_checker.sv
`include "script_word_tokenizer_macros.svh"

module swt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] script_byte_i,
  input logic       buffer_end_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] byte_class_o,
  input logic [7:0] word_char_o,
  input logic       word_done_o,
  input logic [2:0] word_kind_o,
  input logic       length_valid_o,
  input logic [7:0] length_value_o,
  input logic       eof_error_o
);

  logic        out_stall, not_char, len_shown, kind_shown;
  logic [24:0] shown;

  assign out_stall  = out_valid_o && !out_ready_i;
  assign not_char   = out_valid_o && (byte_class_o != swt_pkg::CLS_CHAR);
  assign len_shown  = out_valid_o && length_valid_o;
  assign kind_shown = out_valid_o && (word_kind_o != swt_pkg::KIND_ORD);
  assign shown      = {byte_class_o, word_char_o, word_done_o, word_kind_o,
                       length_valid_o, length_value_o, eof_error_o};

  `SWT_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(shown), "stalled result changed")
  `SWT_ASSERT(a_char_only_in_word, not_char |-> word_char_o == 8'd0, "word_char off a word char")
  `SWT_ASSERT(a_len_at_close, len_shown |-> byte_class_o == swt_pkg::CLS_CLOSE, "length off close")
  `SWT_ASSERT(a_kind_needs_done, kind_shown |-> word_done_o, "word kind without a finished word")
  `SWT_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

bind script_word_tokenizer swt_checker u_swt_checker (.*);
